FILE: src/bmbd_pkg.sv
package bmbd_pkg;

  localparam int VIDEO_BANKS_DEF = 2;
  localparam int WORK_BANKS_DEF  = 8;

  localparam int VIDEO_BANK_SIZE = 8192;
  localparam int VIDEO_OFS_W     = 13;
  localparam int WORK_BANK_SIZE  = 4096;
  localparam int WORK_OFS_W      = 12;

  // flat store only keeps 0x8000-0xffff, lower half is never written
  localparam int FLAT_DEPTH = 32768;
  localparam int FLAT_AW    = 15;

  localparam int CFG_AW         = 3;
  localparam int REG_COLOR_MODE = 0;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [15:0] VIDEO_LO       = 16'h8000;
  localparam logic [15:0] VIDEO_HI       = 16'h9FFF;
  localparam logic [15:0] WORK_LO        = 16'hC000;
  localparam logic [15:0] WORK_UPPER     = 16'hD000;
  localparam logic [15:0] WORK_HI        = 16'hDFFF;
  localparam logic [15:0] ECHO_LO        = 16'hE000;
  localparam logic [15:0] ECHO_HI        = 16'hFDFF;
  localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
  localparam logic [15:0] MIRROR_UP_LAST = ECHO_HI - ECHO_OFFSET;

  localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
  localparam logic [15:0] ADDR_SOUND_ON = 16'hFF26;
  localparam logic [15:0] ADDR_SCANLINE = 16'hFF44;
  localparam logic [15:0] ADDR_DMA      = 16'hFF46;
  localparam logic [15:0] ADDR_SPEED    = 16'hFF4D;
  localparam logic [15:0] ADDR_VBANK    = 16'hFF4F;
  localparam logic [15:0] ADDR_WBANK    = 16'hFF70;

  localparam logic [7:0] SOUND_MASK = 8'h80;
  localparam logic [7:0] SPEED_MASK = 8'h01;
  localparam logic [2:0] WBANK_MASK = 3'h7;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SECOND,
    ST_HOLD
  } state_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_VIDEO,
    K_WORK,
    K_FLAT,
    K_MIRROR_UP,
    K_MIRROR_DOWN,
    K_SOUND,
    K_SPEED,
    K_SCANLINE
  } kind_t;

  function automatic kind_t decode(logic func, logic [15:0] a, logic color);
    kind_t k;
    k = K_NONE;
    if (func == FUNC_READ) begin
      if (a >= VIDEO_LO && a <= VIDEO_HI) k = K_VIDEO;
      else if (color && a >= WORK_LO && a <= WORK_HI) k = K_WORK;
      else if (a >= VIDEO_LO) k = K_FLAT;
    end else begin
      if (a >= VIDEO_LO && a <= VIDEO_HI) k = K_VIDEO;
      else if (a == ADDR_SOUND_ON) k = K_SOUND;
      else if (a == ADDR_SCANLINE) k = K_SCANLINE;
      else if (a == ADDR_DMA) k = K_NONE;
      else if (a >= WORK_LO && a <= WORK_HI) k = color ? K_WORK : K_MIRROR_UP;
      else if (a >= ECHO_LO && a <= ECHO_HI) k = K_MIRROR_DOWN;
      else if (a == ADDR_JOYPAD) k = K_NONE;
      else if (a == ADDR_SPEED) k = K_SPEED;
      else if (a >= VIDEO_LO) k = K_FLAT;
    end
    return k;
  endfunction

endpackage

FILE: src/bmbd_ram.sv
module bmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/banked_memory_bus_decoder_top.sv
// Bus access decoder with banked video and work RAM.
// Input channel (in_valid/in_stall): one access per beat, in_func selects
// read or write, in_address and in_data carry the rest. Output channel
// (out_valid/out_stall): one beat per access, out_read_data holds the byte
// read, or zero for a write.
// An accepted access is registered along with its RAM read; in the ST_SECOND
// state its result goes to the output register, or to pend_r if it is busy.
// The block takes no new access until it has finished with the last one:
// the flat store is a single-port RAM, and the ST_SECOND state is used for
// the echo mirror write or the write-back of a masked register update; reads
// use it to return the registered RAM data.
// The color_mode register is written over the APB-style port; pready is tied
// high.
// After reset the block runs a clearing pass that zeroes the flat, video and
// work stores; in_stall stays high during the pass.
// When the receiver stalls, the result waits in the output register; the
// next access is still taken and its result parks in a holding register,
// after which in_stall stays high until the output register frees up.
module banked_memory_bus_decoder_top #(
  parameter int VIDEO_BANKS = bmbd_pkg::VIDEO_BANKS_DEF,
  parameter int WORK_BANKS  = bmbd_pkg::WORK_BANKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [15:0]                 in_address,
  input  logic [7:0]                  in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_read_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmbd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bmbd_pkg::*;

  localparam int VIDEO_DEPTH = VIDEO_BANKS * VIDEO_BANK_SIZE;
  localparam int VIDEO_AW    = $clog2(VIDEO_DEPTH);
  localparam int WORK_DEPTH  = WORK_BANKS * WORK_BANK_SIZE;
  localparam int WORK_AW     = $clog2(WORK_DEPTH);
  localparam int WORK_BW     = WORK_AW - WORK_OFS_W;

  function automatic logic [WORK_BW-1:0] bank_mod(logic [2:0] sel);
    logic [WORK_BW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (sel == 3'(i)) r = WORK_BW'(i % WORK_BANKS);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [FLAT_AW-1:0] clr_cnt_r;
  logic               color_mode_r;
  logic               vsel_r;
  logic [2:0]         wsel_r;

  kind_t       kind_r;
  logic        func_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [7:0] pend_r;

  logic       accept, out_free, clr_last;
  kind_t      kind_in;
  logic [7:0] result;

  logic               f_en, f_we;
  logic [FLAT_AW-1:0] f_addr;
  logic [7:0]         f_wdata, f_rdata;
  logic               v_en, v_we;
  logic [VIDEO_AW-1:0] v_addr;
  logic [7:0]         v_wdata, v_rdata;
  logic               w_en, w_we;
  logic [WORK_AW-1:0] w_addr;
  logic [7:0]         w_wdata, w_rdata;

  logic               vbank_use;
  logic [WORK_BW-1:0] wbank_in;
  logic [15:0]        up_addr, down_addr;
  logic               cfg_wr;
  logic [CFG_AW-3:0]  reg_idx;

  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_cnt_r == FLAT_AW'(FLAT_DEPTH - 1));
  assign kind_in  = decode(in_func, in_address, color_mode_r);

  assign vbank_use = color_mode_r && vsel_r && (VIDEO_BANKS > 1);
  assign wbank_in  = (in_address >= WORK_UPPER) ? bank_mod(wsel_r) : '0;
  assign up_addr   = addr_r + ECHO_OFFSET;
  assign down_addr = addr_r - ECHO_OFFSET;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == (CFG_AW-2)'(REG_COLOR_MODE)) ? {31'b0, color_mode_r} : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_SECOND;
      ST_SECOND: state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    f_en    = 1'b0;
    f_we    = 1'b0;
    f_addr  = in_address[FLAT_AW-1:0];
    f_wdata = in_data;
    v_en    = 1'b0;
    v_we    = 1'b0;
    v_addr  = VIDEO_AW'({vbank_use, in_address[VIDEO_OFS_W-1:0]});
    v_wdata = in_data;
    w_en    = 1'b0;
    w_we    = 1'b0;
    w_addr  = {wbank_in, in_address[WORK_OFS_W-1:0]};
    w_wdata = in_data;
    unique case (state_r)
      ST_CLEAR: begin
        f_en    = 1'b1;
        f_we    = 1'b1;
        f_addr  = clr_cnt_r;
        f_wdata = '0;
        v_en    = 32'(clr_cnt_r) < VIDEO_DEPTH;
        v_we    = 1'b1;
        v_addr  = clr_cnt_r[VIDEO_AW-1:0];
        v_wdata = '0;
        w_en    = 32'(clr_cnt_r) < WORK_DEPTH;
        w_we    = 1'b1;
        w_addr  = clr_cnt_r[WORK_AW-1:0];
        w_wdata = '0;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_in)
            K_VIDEO: begin
              v_en = 1'b1;
              v_we = in_func;
            end
            K_WORK: begin
              w_en = 1'b1;
              w_we = in_func;
            end
            K_FLAT, K_MIRROR_UP, K_MIRROR_DOWN: begin
              f_en = 1'b1;
              f_we = in_func;
            end
            K_SOUND, K_SPEED: f_en = 1'b1;
            K_SCANLINE: begin
              f_en    = 1'b1;
              f_we    = 1'b1;
              f_wdata = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SECOND: begin
        f_wdata = data_r;
        f_addr  = addr_r[FLAT_AW-1:0];
        case (kind_r)
          K_MIRROR_UP: begin
            // mirror stops at the top of echo ram
            f_en   = (addr_r <= MIRROR_UP_LAST);
            f_we   = 1'b1;
            f_addr = up_addr[FLAT_AW-1:0];
          end
          K_MIRROR_DOWN: begin
            f_en   = 1'b1;
            f_we   = 1'b1;
            f_addr = down_addr[FLAT_AW-1:0];
          end
          K_SOUND: begin
            f_en    = 1'b1;
            f_we    = 1'b1;
            f_wdata = (f_rdata & ~SOUND_MASK) | (data_r & SOUND_MASK);
          end
          K_SPEED: begin
            f_en    = 1'b1;
            f_we    = 1'b1;
            f_wdata = (f_rdata & ~SPEED_MASK) | (data_r & SPEED_MASK);
          end
          default: ;
        endcase
      end
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_comb begin
    result = '0;
    if (func_r == FUNC_READ) begin
      case (kind_r)
        K_VIDEO: result = v_rdata;
        K_WORK:  result = w_rdata;
        K_FLAT:  result = f_rdata;
        default: result = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      color_mode_r <= 1'b0;
      vsel_r       <= 1'b0;
      wsel_r       <= 3'd1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cfg_wr && reg_idx == (CFG_AW-2)'(REG_COLOR_MODE)) color_mode_r <= pwdata[0];
      if (accept && in_func == FUNC_WRITE && in_address == ADDR_VBANK) vsel_r <= in_data[0];
      if (accept && in_func == FUNC_WRITE && in_address == ADDR_WBANK) begin
        // bank zero selects bank one
        wsel_r <= ((in_data[2:0] & WBANK_MASK) == 3'd0) ? 3'd1 : (in_data[2:0] & WBANK_MASK);
      end
      if ((state_r == ST_SECOND || state_r == ST_HOLD) && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_in;
      func_r <= in_func;
      addr_r <= in_address;
      data_r <= in_data;
    end
    if (state_r == ST_SECOND) begin
      if (out_free) out_data_r <= result;
      else pend_r <= result;
    end else if (state_r == ST_HOLD && out_free) begin
      out_data_r <= pend_r;
    end
  end

  bmbd_ram #(.WIDTH(8), .DEPTH(FLAT_DEPTH)) u_flat_ram (
    .clk   (clk),
    .en    (f_en),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (f_rdata)
  );

  bmbd_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video_ram (
    .clk   (clk),
    .en    (v_en),
    .we    (v_we),
    .addr  (v_addr),
    .wdata (v_wdata),
    .rdata (v_rdata)
  );

  bmbd_ram #(.WIDTH(8), .DEPTH(WORK_DEPTH)) u_work_ram (
    .clk   (clk),
    .en    (w_en),
    .we    (w_we),
    .addr  (w_addr),
    .wdata (w_wdata),
    .rdata (w_rdata)
  );

`ifndef SYNTH
  a_accept_to_second: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SECOND)
    else $error("accepted beat did not move to second cycle");

  a_hold_needs_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> out_valid_r)
    else $error("holding a result while the output register is empty");

  a_out_kept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result overwritten");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> in_stall && !out_valid_r)
    else $error("traffic during clearing pass");
`endif

endmodule
